// ===== design/ssht_pkg.sv =====
package ssht_pkg;

  // Width of one multiplier operand in the product compare.
  localparam int unsigned LIMB_WIDTH = 32;

  // Load enables for the three product-compare stages.
  typedef struct packed {
    logic pp;
    logic row;
    logic tot;
  } stage_en_t;

endpackage

// ===== design/segment_sphere_hit_test.sv =====
// Segment/sphere hit test. Each item gives a segment origin O, a direction D
// whose length is the segment length, a sphere centre S and a squared radius,
// all fixed point with FRAC_BITS fraction bits; hit_o is 1 when some point of
// the closed segment lies in the closed ball (touching counts). The test is
// exact, with no rounding. A zero-length segment hits only when its origin is
// inside the ball. The block is an 8-stage pipeline: one item per cycle when
// the output is not stalled, and the result leaves from the stage 8 register.
// Per-stage valid bits let bubbles fill up behind a stalled output.
module segment_sphere_hit_test #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [COORD_WIDTH-1:0] dir_x_i,
  input  logic signed [COORD_WIDTH-1:0] dir_y_i,
  input  logic signed [COORD_WIDTH-1:0] dir_z_i,
  input  logic signed [COORD_WIDTH-1:0] centre_x_i,
  input  logic signed [COORD_WIDTH-1:0] centre_y_i,
  input  logic signed [COORD_WIDTH-1:0] centre_z_i,
  input  logic        [COORD_WIDTH-1:0] radius_squared_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic                          hit_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned MW   = W + 1;
  localparam int unsigned BW   = 2 * W + 3;
  localparam int unsigned L2W  = 2 * W + 1;
  localparam int unsigned MMW  = 2 * W + 3;
  localparam int unsigned R2W  = W + FRAC_BITS + 1;
  localparam int unsigned CSW  = ((MMW > R2W) ? MMW : R2W) + 1;
  localparam int unsigned EW   = CSW + 2;
  localparam int unsigned PW   = 2 * W + 2;
  localparam int unsigned NST  = 8;

  logic [NST:1]   v_q;
  logic [NST:1]   v_in;
  logic [NST+1:1] rdy;

  always_comb begin
    rdy[NST+1] = !stall_i;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign v_in    = {v_q[NST-1:1], valid_i};
  assign stall_o = !rdy[1];
  assign valid_o = v_q[NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (rdy[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // stage 1: relative origin
  logic signed [MW-1:0] m_q [3];
  logic signed [W-1:0]  d_q [3];
  logic [W-1:0]         r2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      m_q[0] <= MW'(origin_x_i) - MW'(centre_x_i);
      m_q[1] <= MW'(origin_y_i) - MW'(centre_y_i);
      m_q[2] <= MW'(origin_z_i) - MW'(centre_z_i);
      d_q[0] <= dir_x_i;
      d_q[1] <= dir_y_i;
      d_q[2] <= dir_z_i;
      r2_q   <= radius_squared_i;
    end
  end

  // stage 2: per-axis products
  logic signed [2*W:0]   md_q [3];
  logic signed [2*W-1:0] dd_q [3];
  logic signed [2*W+1:0] mm_q [3];
  logic [W-1:0]          r2_2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        md_q[i] <= (2*W+1)'(m_q[i]) * (2*W+1)'(d_q[i]);
        dd_q[i] <= (2*W)'(d_q[i]) * (2*W)'(d_q[i]);
        mm_q[i] <= (2*W+2)'(m_q[i]) * (2*W+2)'(m_q[i]);
      end
      r2_2_q <= r2_q;
    end
  end

  // stage 3: B = M.D, L2 = D.D, C = M.M - R2
  logic signed [BW-1:0]  b_q;
  logic signed [L2W-1:0] l2_q;
  logic signed [CSW-1:0] c_q;
  logic signed [CSW-1:0] r2s;

  assign r2s = $signed(CSW'({r2_2_q, FRAC_BITS'(0)}));

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      b_q  <= BW'(md_q[0]) + BW'(md_q[1]) + BW'(md_q[2]);
      l2_q <= L2W'(dd_q[0]) + L2W'(dd_q[1]) + L2W'(dd_q[2]);
      c_q  <= CSW'(mm_q[0]) + CSW'(mm_q[1]) + CSW'(mm_q[2]) - r2s;
    end
  end

  // stage 4: case split; only the closest-approach case needs the products
  logic signed [EW-1:0] near_sum, end_sum;
  logic c_le0, l2_zero, b_neg, near_in, end_in;
  logic known_d, val_d;

  assign near_sum = EW'(b_q) + EW'(l2_q);
  assign end_sum  = EW'(l2_q) + EW'(b_q) + EW'(b_q) + EW'(c_q);
  assign c_le0    = c_q[CSW-1] || (c_q == '0);
  assign l2_zero  = (l2_q == '0);
  assign b_neg    = b_q[BW-1];
  assign near_in  = !near_sum[EW-1];
  assign end_in   = end_sum[EW-1] || (end_sum == '0);

  always_comb begin
    known_d = c_le0 || l2_zero || !b_neg || !near_in;
    if (c_le0) begin
      val_d = 1'b1;
    end else if (l2_zero || !b_neg) begin
      val_d = 1'b0;
    end else begin
      val_d = end_in;
    end
  end

  logic [NST-1:4] known_q, val_q;
  logic [PW-1:0]  bm_q, cm_q, l2m_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      known_q[4] <= known_d;
      val_q[4]   <= val_d;
      bm_q       <= PW'(-b_q);
      cm_q       <= PW'(c_q);
      l2m_q      <= PW'(l2_q);
    end
    for (int k = 5; k <= NST - 1; k++) begin
      if (rdy[k]) begin
        known_q[k] <= known_q[k-1];
        val_q[k]   <= val_q[k-1];
      end
    end
  end

  // stages 5..7: B*B against C*L2
  ssht_pkg::stage_en_t cmp_en;
  logic                prod_le;

  assign cmp_en.pp  = rdy[5];
  assign cmp_en.row = rdy[6];
  assign cmp_en.tot = rdy[7];

  ssht_prod_cmp #(
    .PW (PW)
  ) u_prod_cmp (
    .clk_i (clk_i),
    .en_i  (cmp_en),
    .b_i   (bm_q),
    .c_i   (cm_q),
    .l2_i  (l2m_q),
    .le_o  (prod_le)
  );

  // stage 8: output register
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (rdy[NST]) begin
      hit_q <= known_q[NST-1] ? val_q[NST-1] : prod_le;
    end
  end

  assign hit_o = hit_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled while the pipeline has a bubble");

  a_stage_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && rdy[2]) |=> v_q[2])
    else $error("item lost between stage 1 and stage 2");

  a_held_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && !rdy[5]) |=> (v_q[4] && $stable(known_q[4]) && $stable(val_q[4])))
    else $error("held stage 4 decision changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !valid_o)
    else $error("result valid during reset");

endmodule

// ===== design/ssht_prod_cmp.sv =====
// Three-stage exact compare: le_o = (c_i * l2_i <= b_i * b_i), all unsigned.
module ssht_prod_cmp #(
  parameter int unsigned PW = 66
) (
  input  logic                  clk_i,
  input  ssht_pkg::stage_en_t   en_i,
  input  logic [PW-1:0]         b_i,
  input  logic [PW-1:0]         c_i,
  input  logic [PW-1:0]         l2_i,
  output logic                  le_o
);

  localparam int unsigned LB   = ssht_pkg::LIMB_WIDTH;
  localparam int unsigned NL   = (PW + LB - 1) / LB;
  localparam int unsigned LW   = NL * LB;
  localparam int unsigned PPW  = 2 * LB;
  localparam int unsigned ROWW = LW + LB;
  localparam int unsigned TOTW = 2 * LW;

  logic [LW-1:0] b_ext, c_ext, l2_ext;

  logic [PPW-1:0]  pp_bb_q [NL][NL];
  logic [PPW-1:0]  pp_cl_q [NL][NL];
  logic [ROWW-1:0] row_bb_d [NL];
  logic [ROWW-1:0] row_cl_d [NL];
  logic [ROWW-1:0] row_bb_q [NL];
  logic [ROWW-1:0] row_cl_q [NL];
  logic [TOTW-1:0] tot_bb_d, tot_cl_d;
  logic [TOTW-1:0] tot_bb_q, tot_cl_q;

  assign b_ext  = LW'(b_i);
  assign c_ext  = LW'(c_i);
  assign l2_ext = LW'(l2_i);

  // limb partial products
  always_ff @(posedge clk_i) begin
    if (en_i.pp) begin
      for (int i = 0; i < NL; i++) begin
        for (int j = 0; j < NL; j++) begin
          pp_bb_q[i][j] <= PPW'(b_ext[i*LB +: LB]) * PPW'(b_ext[j*LB +: LB]);
          pp_cl_q[i][j] <= PPW'(c_ext[i*LB +: LB]) * PPW'(l2_ext[j*LB +: LB]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      row_bb_d[i] = '0;
      row_cl_d[i] = '0;
      for (int j = 0; j < NL; j++) begin
        row_bb_d[i] = row_bb_d[i] + (ROWW'(pp_bb_q[i][j]) << (j * LB));
        row_cl_d[i] = row_cl_d[i] + (ROWW'(pp_cl_q[i][j]) << (j * LB));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.row) begin
      row_bb_q <= row_bb_d;
      row_cl_q <= row_cl_d;
    end
  end

  always_comb begin
    tot_bb_d = '0;
    tot_cl_d = '0;
    for (int i = 0; i < NL; i++) begin
      tot_bb_d = tot_bb_d + (TOTW'(row_bb_q[i]) << (i * LB));
      tot_cl_d = tot_cl_d + (TOTW'(row_cl_q[i]) << (i * LB));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.tot) begin
      tot_bb_q <= tot_bb_d;
      tot_cl_q <= tot_cl_d;
    end
  end

  assign le_o = (tot_cl_q <= tot_bb_q);

endmodule
